// ===== hdl/ripc_pkg.sv =====
// ripc_pkg: sizes, types, command codes and helper functions for the
// ranking inversion pair counter and its checker; depends on nothing else

package ripc_pkg;

    localparam int RANK_COUNT  = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int RANK_W      = (RANK_COUNT > 1) ? $clog2(RANK_COUNT) : 1;

    localparam int FIELD_W     = 4;
    localparam int IN_FIELDS_W = 3 * FIELD_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 16;
    localparam int OUT_DATA_W  = 2 * OUT_FIELD_W;

    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef count_t [RANK_COUNT-1:0] col_t;
    typedef logic [RANK_W-1:0]       rank_idx_t;
    typedef logic [FIELD_W-1:0]      field_t;
    typedef logic [RANK_COUNT-1:0]   seen_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    localparam count_t COUNT_MAX = '1;

    function automatic logic in_range(input field_t f);
        return (32'(f) < RANK_COUNT);
    endfunction

    function automatic rank_idx_t to_idx(input field_t f);
        return RANK_W'(f);
    endfunction

    function automatic count_t sat_inc(input count_t c);
        return (c == COUNT_MAX) ? c : count_t'(c + count_t'(1));
    endfunction

endpackage

// ===== hdl/ranking_inversion_pair_counter.sv =====
// ranking_inversion_pair_counter: top level, inversion matrix held as one
// memory row per smaller rank value, read-modify-write in a single stage
// depends on ripc_pkg
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata rank/read_high/read_low, tuser cmd, tlast row end
//  m_*     | out | m_tvalid/m_tready  | tdata pair_count, rows_counted
//
// one item per cycle unless a read meets a full, stalled output; a read result passes
// the stage register and then the output register; the column memory has one read port;
// an item after a push to its column takes a write bypass, so the single stage keeps full rate
// reset clears per-column valid bits at once, no clearing pass is needed
// a read held in the stage by a full, stalled output register holds the input

module ranking_inversion_pair_counter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ripc_pkg::IN_DATA_W-1:0] s_tdata,   // rank_value, read_high, read_low
    input  logic                           s_tuser,   // cmd
    input  logic                           s_tlast,   // end_of_row
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ripc_pkg::OUT_DATA_W-1:0] m_tdata   // pair_count, rows_counted
);
    import ripc_pkg::*;

    // input side
    logic      in_xfer;
    cmd_t      in_cmd;
    field_t    in_rank, in_high, in_low;
    rank_idx_t in_addr;
    logic      in_addr_ok;

    // single work stage
    logic      s1_valid_reg;
    cmd_t      s1_cmd_reg;
    field_t    s1_rank_reg, s1_high_reg, s1_low_reg;
    logic      s1_eor_reg;
    col_t      s1_col_reg;
    logic      s1_fire;
    logic      s1_push, s1_read;
    rank_idx_t x_idx;
    logic      wr_en;
    col_t      col_upd;
    count_t    pair_sel;

    // state
    col_t                  col_mem [RANK_COUNT];
    logic [RANK_COUNT-1:0] col_valid_reg, col_valid_next;
    seen_t                 seen_reg, seen_next;
    count_t                rows_reg, rows_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_rank = s_tdata[FIELD_W-1:0];
    assign in_high = s_tdata[2*FIELD_W-1:FIELD_W];
    assign in_low  = s_tdata[3*FIELD_W-1:2*FIELD_W];

    // a read of entry [high][low] lives in column low
    assign in_addr    = (in_cmd == CMD_READ) ? to_idx(in_low) : to_idx(in_rank);
    assign in_addr_ok = (in_cmd == CMD_READ) ? in_range(in_low) : in_range(in_rank);

    assign s1_push = s1_valid_reg && (s1_cmd_reg == CMD_PUSH);
    assign s1_read = s1_valid_reg && (s1_cmd_reg == CMD_READ);
    assign s1_fire = s1_valid_reg && (!s1_read || !out_valid_reg || m_tready);

    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_xfer  = s_tvalid && s_tready;

    assign x_idx = to_idx(s1_rank_reg);
    assign wr_en = s1_fire && s1_push && in_range(s1_rank_reg);

    // every larger value already seen in this row bumps its counter
    always_comb
    begin
        col_upd = s1_col_reg;
        for (int v = 0; v < RANK_COUNT; v++)
        begin
            if ((v > int'(x_idx)) && seen_reg[v])
            begin
                col_upd[v] = sat_inc(s1_col_reg[v]);
            end
        end
    end

    always_comb
    begin
        pair_sel = '0;
        if (in_range(s1_high_reg) && in_range(s1_low_reg))
        begin
            pair_sel = s1_col_reg[to_idx(s1_high_reg)];
        end
    end

    always_comb
    begin
        seen_next      = seen_reg;
        rows_next      = rows_reg;
        col_valid_next = col_valid_reg;
        if (wr_en)
        begin
            seen_next[x_idx]      = 1'b1;
            col_valid_next[x_idx] = 1'b1;
        end
        if (s1_fire && s1_push && s1_eor_reg)
        begin
            seen_next = '0;
            rows_next = sat_inc(rows_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            rows_reg      <= '0;
            col_valid_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
            rows_reg      <= rows_next;
            col_valid_reg <= col_valid_next;
        end
    end

    // column memory with write-through bypass to the stage register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[x_idx] <= col_upd;
        end
        if (in_xfer)
        begin
            s1_cmd_reg  <= in_cmd;
            s1_rank_reg <= in_rank;
            s1_high_reg <= in_high;
            s1_low_reg  <= in_low;
            s1_eor_reg  <= s_tlast;
            if (!in_addr_ok)
            begin
                s1_col_reg <= '0;
            end
            else if (wr_en && (x_idx == in_addr))
            begin
                s1_col_reg <= col_upd;
            end
            else if (col_valid_reg[in_addr])
            begin
                s1_col_reg <= col_mem[in_addr];
            end
            else
            begin
                s1_col_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_read)
        begin
            out_data_reg <= {OUT_FIELD_W'(rows_reg), OUT_FIELD_W'(pair_sel)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hdl/ripc_checker.sv =====
// ripc_checker: port-level assertions for the ranking inversion pair counter,
// bound to the top level below; depends on ripc_pkg

module ripc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,   // cmd
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ripc_pkg::OUT_DATA_W-1:0] m_tdata    // pair_count, rows_counted
);
    import ripc_pkg::*;

    logic                   read_in, result_out;
    logic [1:0]             pend_reg, pend_next;
    logic [OUT_FIELD_W-1:0] last_rows_reg;

    assign read_in    = s_tvalid && s_tready && (cmd_t'(s_tuser) == CMD_READ);
    assign result_out = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (read_in && !result_out)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!read_in && result_out)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            last_rows_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (result_out)
            begin
                last_rows_reg <= m_tdata[OUT_DATA_W-1:OUT_FIELD_W];
            end
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // every result belongs to a read that is still owed
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pend_reg != 2'd0))
        else $error("result without an outstanding read");

    // stage plus output register hold at most two reads
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two reads in flight");

    // the row count never goes backwards
    a_rows_mono: assert property (@(posedge clk) disable iff (!rst_n)
        result_out |-> (m_tdata[OUT_DATA_W-1:OUT_FIELD_W] >= last_rows_reg))
        else $error("rows_counted decreased");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result shown straight after reset");

endmodule

bind ranking_inversion_pair_counter ripc_checker u_ripc_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for ranking_inversion_pair_counter, with a
// matrix predictor, directed table, random rankings and a back-to-back tail
// depends on ripc_pkg and the rtl top level only

module tb_top;

    import ripc_pkg::*;

    localparam int RANDOM_ITEMS = 820;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        cmd_t        cmd;
        field_t      rank;
        logic        eor;
        field_t      hi;
        field_t      lo;
        bit          typed;
        logic [15:0] pc;
        logic [15:0] rows;
    } rank_item_t;

    typedef struct {
        logic [15:0] pc;
        logic [15:0] rows;
        field_t      hi;
        field_t      lo;
    } read_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;    // rank_value, read_high, read_low
    logic                   s_tuser = 1'b0;  // cmd
    logic                   s_tlast = 1'b0;  // end_of_row
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;         // pair_count, rows_counted

    // predictor state
    count_t pair_tally [RANK_COUNT][RANK_COUNT];
    seen_t  seen_mask;
    count_t rows_done;
    read_result_t awaited_reads [$];

    int  items_sent;
    int  results_seen;
    int  mismatches;
    int  in_stalls;
    int  burst_left;
    bit  steady_sender;
    bit  hold_wanted;
    bit  hold_done;

    rank_item_t opening_table [20];

    ranking_inversion_pair_counter dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic count_t bump(input count_t c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : count_t'(c + 1'b1);
    endfunction

    function automatic rank_item_t push_of(input field_t v, input logic e);
        rank_item_t r;
        r.cmd   = CMD_PUSH;
        r.rank  = v;
        r.eor   = e;
        r.hi    = field_t'($urandom);
        r.lo    = field_t'($urandom);
        r.typed = 1'b0;
        r.pc    = '0;
        r.rows  = '0;
        return r;
    endfunction

    function automatic rank_item_t read_of(input field_t h, input field_t l);
        rank_item_t r;
        r.cmd   = CMD_READ;
        r.rank  = field_t'($urandom);
        r.eor   = 1'($urandom);
        r.hi    = h;
        r.lo    = l;
        r.typed = 1'b0;
        r.pc    = '0;
        r.rows  = '0;
        return r;
    endfunction

    // mostly entries below the diagonal, where counts can be non-zero
    function automatic rank_item_t random_read();
        int h;
        if ($urandom_range(0, 9) < 7)
        begin
            h = $urandom_range(1, RANK_COUNT - 1);
            return read_of(field_t'(h), field_t'($urandom_range(0, h - 1)));
        end
        return read_of(field_t'($urandom), field_t'($urandom));
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // matrix update for a push, expected result for a read
    task automatic account_item(input rank_item_t r);
        read_result_t res;
        int v;
        if (r.cmd == CMD_READ)
        begin
            res.hi   = r.hi;
            res.lo   = r.lo;
            res.pc   = (int'(r.hi) < RANK_COUNT && int'(r.lo) < RANK_COUNT) ?
                       16'(pair_tally[r.hi][r.lo]) : 16'd0;
            res.rows = 16'(rows_done);
            if (r.typed)
            begin
                res.pc   = r.pc;
                res.rows = r.rows;
            end
            awaited_reads.push_back(res);
        end
        else
        begin
            if (int'(r.rank) < RANK_COUNT)
            begin
                for (v = int'(r.rank) + 1; v < RANK_COUNT; v++)
                    if (seen_mask[v])
                        pair_tally[v][r.rank] = bump(pair_tally[v][r.rank]);
                seen_mask[r.rank] = 1'b1;
            end
            if (r.eor)
            begin
                seen_mask = '0;
                rows_done = bump(rows_done);
            end
        end
    endtask

    task automatic send_item(input rank_item_t r);
        int gap;
        bit took;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({r.lo, r.hi, r.rank});
        s_tuser  <= r.cmd;
        s_tlast  <= r.eor;
        // ready is sampled mid-cycle; the transfer lands on the next rising edge
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        items_sent++;
        account_item(r);
    endtask

    // a well-formed ranking, or a broken one with repeats and an early, late or missing end
    task automatic send_ranking(input bit broken);
        field_t order [RANK_COUNT];
        field_t t;
        field_t v;
        int len;
        int i;
        int j;
        logic e;
        for (i = 0; i < RANK_COUNT; i++)
            order[i] = field_t'(i);
        for (i = RANK_COUNT - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        len = broken ? $urandom_range(1, 20) : RANK_COUNT;
        for (i = 0; i < len; i++)
        begin
            v = (broken && $urandom_range(0, 3) == 0) ? field_t'($urandom)
                                                     : order[i % RANK_COUNT];
            e = (i == len - 1) && !(broken && $urandom_range(0, 5) == 0);
            send_item(push_of(v, e));
            if ($urandom_range(0, 5) == 0)
                send_item(random_read());
        end
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        read_result_t want;
        if (awaited_reads.size() == 0)
        begin
            report_mismatch("result with no read outstanding, pair_count", 16'd0, word[15:0]);
            return;
        end
        want = awaited_reads.pop_front();
        results_seen++;
        if (word[15:0] !== want.pc)
            report_mismatch($sformatf("pair_count [%0d][%0d]", want.hi, want.lo),
                            want.pc, word[15:0]);
        if (word[31:16] !== want.rows)
            report_mismatch($sformatf("rows_counted at read [%0d][%0d]", want.hi, want.lo),
                            want.rows, word[31:16]);
    endtask

    // input stalls and output transfers, seen mid-cycle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !s_tready)
                in_stalls++;
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
    end

    // receiver: rotating stall pattern, plus one long hold-off on request
    initial
    begin : receiver
        logic [7:0] pat;
        int left;
        pat  = 8'hff;
        left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    left = $urandom_range(16, 80);
                    pat  = ($urandom_range(0, 2) == 0) ? 8'hff : (8'($urandom) | 8'h01);
                end
                left--;
                pat = {pat[6:0], pat[7]};
                m_tready <= pat[0];
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, awaited_reads.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int n0;
        seen_mask = '0;
        rows_done = '0;
        for (i = 0; i < RANK_COUNT * RANK_COUNT; i++)
            pair_tally[i / RANK_COUNT][i % RANK_COUNT] = '0;
        items_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        in_stalls     = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        hold_wanted   = 1'b0;
        hold_done     = 1'b0;

        // cmd, rank, eor, read_high, read_low, typed, pair_count, rows_counted
        opening_table = '{
            '{CMD_READ, 4'd0,  1'b0, 4'd15, 4'd0,  1'b1, 16'd0, 16'd0},  // cleared at reset
            '{CMD_READ, 4'd0,  1'b0, 4'd0,  4'd15, 1'b1, 16'd0, 16'd0},
            '{CMD_PUSH, 4'd15, 1'b0, 4'd0,  4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_PUSH, 4'd0,  1'b0, 4'd15, 4'd15, 1'b0, 16'd0, 16'd0},
            '{CMD_PUSH, 4'd0,  1'b0, 4'd0,  4'd0,  1'b0, 16'd0, 16'd0},  // repeated value
            '{CMD_PUSH, 4'd7,  1'b1, 4'd0,  4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_READ, 4'd0,  1'b0, 4'd15, 4'd0,  1'b1, 16'd2, 16'd1},
            '{CMD_READ, 4'd0,  1'b0, 4'd15, 4'd7,  1'b1, 16'd1, 16'd1},
            '{CMD_READ, 4'd0,  1'b0, 4'd7,  4'd15, 1'b1, 16'd0, 16'd1},  // above the diagonal
            '{CMD_READ, 4'd15, 1'b1, 4'd5,  4'd5,  1'b1, 16'd0, 16'd1},  // end mark ignored
            '{CMD_PUSH, 4'd3,  1'b0, 4'd0,  4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_PUSH, 4'd2,  1'b0, 4'd0,  4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_PUSH, 4'd1,  1'b0, 4'd0,  4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_PUSH, 4'd0,  1'b1, 4'd0,  4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_READ, 4'd0,  1'b0, 4'd3,  4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_READ, 4'd0,  1'b0, 4'd2,  4'd1,  1'b0, 16'd0, 16'd0},
            '{CMD_READ, 4'd0,  1'b0, 4'd15, 4'd15, 1'b1, 16'd0, 16'd2},
            '{CMD_PUSH, 4'd15, 1'b1, 4'd15, 4'd0,  1'b0, 16'd0, 16'd0},  // one-value row
            '{CMD_READ, 4'd0,  1'b0, 4'd10, 4'd0,  1'b0, 16'd0, 16'd0},
            '{CMD_READ, 4'd15, 1'b1, 4'd15, 4'd0,  1'b0, 16'd0, 16'd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(opening_table); i++)
            send_item(opening_table[i]);

        // random part, opened by a long output hold-off so the block backs up
        hold_wanted = 1'b1;
        n0 = items_sent;
        while (items_sent < n0 + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                    send_ranking(1'b1);
                3, 4, 5:
                    repeat ($urandom_range(1, 8)) send_item(random_read());
                default:
                    send_ranking(1'b0);
            endcase
        end

        // one full ranking with no sender gaps, then a couple of reads
        steady_sender = 1'b1;
        send_ranking(1'b0);
        send_item(read_of(4'd1, 4'd0));
        send_item(read_of(4'd15, 4'd0));
        steady_sender = 1'b0;
        s_tvalid <= 1'b0;

        while (awaited_reads.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d input transfers, %0d reads checked, %0d cycles of input stall",
                 items_sent, results_seen, in_stalls);
        $display("random and broken rankings, long output hold-off, %0d rows completed",
                 rows_done);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== ranking_inversion_pair_counter.f =====
hdl/ripc_pkg.sv
hdl/ranking_inversion_pair_counter.sv
hdl/ripc_checker.sv
test/tb_top.sv
